// ----- hw/rtl/rsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, beat layouts and payload types shared by the ray/segment datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_W  = 16;               // signed Q8.8 coordinate
    localparam int FRAC_W   = 8;                // fraction bits of the distance
    localparam int DIST_W   = COORD_W + FRAC_W; // unsigned Q16.8 distance
    localparam int TOL_W    = 16;
    localparam int DIFF_W   = COORD_W + 1;      // S - O
    localparam int PROD_W   = DIFF_W + COORD_W; // one product of a cross term
    localparam int CROSS_W  = PROD_W + 1;       // difference of two products
    localparam int DEN_W    = 2 * COORD_W;      // magnitude of the denominator
    localparam int HEAD_W   = CROSS_W - COORD_W; // dividend bits above the fed-in part
    localparam int IN_W     = 8 * COORD_W;
    localparam int OUT_W    = ((DIST_W + 1 + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Packed so that ray_origin_x lands in the lowest bits of the beat.
    typedef struct packed {
        logic signed [COORD_W-1:0] wall_vec_y;
        logic signed [COORD_W-1:0] wall_vec_x;
        logic signed [COORD_W-1:0] wall_start_y;
        logic signed [COORD_W-1:0] wall_start_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_origin_x;
    } rsi_in_t;

    // Payload handed along the divider chain.
    typedef struct packed {
        logic              hit;
        logic              sat;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [DIST_W-1:0] dvd;  // dividend bits still to shift in, MSB first
        logic [DIST_W-1:0] quo;
    } rsi_div_t;

endpackage

// ----- hw/rtl/rsi_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_prep
// Four-stage front end: cross products, differences, sign fold, hit tests.
// ----------------------------------------------------------------------------
module rsi_prep (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [rsi_pkg::TOL_W-1:0]      tolerance,
    input  logic                           in_valid,
    input  rsi_pkg::rsi_in_t               in_data,
    output logic                           in_ready,
    output logic                           out_valid,
    output rsi_pkg::rsi_div_t              out_data,
    input  logic                           out_ready
);

    localparam int PW = rsi_pkg::PROD_W;
    localparam int CW = rsi_pkg::CROSS_W;
    localparam int DW = rsi_pkg::DEN_W;
    localparam int KW = rsi_pkg::COORD_W;

    logic [3:0] valid_reg, valid_next;
    logic [3:0] rdy;

    // stage 1: products
    logic signed [rsi_pkg::DIFF_W-1:0] ax, ay;
    logic signed [PW-1:0] p_dw_reg, p_dyw_reg, p_aw_reg, p_ayw_reg, p_ad_reg, p_ayd_reg;
    // stage 2: cross terms
    logic signed [CW-1:0] den_reg, tn_reg, un_reg;
    // stage 3: folded to a positive denominator
    logic [DW-1:0]        mag_reg;
    logic signed [CW-1:0] tn3_reg, un3_reg;
    logic signed [CW-1:0] den_neg, tn_neg, un_neg;
    // stage 4
    rsi_pkg::rsi_div_t    out_reg, out_next;
    logic [DW-1:0]        head;
    logic                 parallel, t_pos, u_ok;

    assign rdy[3] = !valid_reg[3] || out_ready;
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[3];
    assign out_data  = out_reg;

    always_comb begin
        valid_next = valid_reg;
        if (rdy[0]) valid_next[0] = in_valid;
        if (rdy[1]) valid_next[1] = valid_reg[0];
        if (rdy[2]) valid_next[2] = valid_reg[1];
        if (rdy[3]) valid_next[3] = valid_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ax = $signed({in_data.wall_start_x[KW-1], in_data.wall_start_x})
              - $signed({in_data.ray_origin_x[KW-1], in_data.ray_origin_x});
    assign ay = $signed({in_data.wall_start_y[KW-1], in_data.wall_start_y})
              - $signed({in_data.ray_origin_y[KW-1], in_data.ray_origin_y});

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            p_dw_reg  <= PW'(in_data.ray_dir_x * in_data.wall_vec_y);
            p_dyw_reg <= PW'(in_data.ray_dir_y * in_data.wall_vec_x);
            p_aw_reg  <= PW'(ax * in_data.wall_vec_y);
            p_ayw_reg <= PW'(ay * in_data.wall_vec_x);
            p_ad_reg  <= PW'(ax * in_data.ray_dir_y);
            p_ayd_reg <= PW'(ay * in_data.ray_dir_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1] && valid_reg[0]) begin
            den_reg <= $signed({p_dw_reg[PW-1], p_dw_reg}) - $signed({p_dyw_reg[PW-1], p_dyw_reg});
            tn_reg  <= $signed({p_aw_reg[PW-1], p_aw_reg}) - $signed({p_ayw_reg[PW-1], p_ayw_reg});
            un_reg  <= $signed({p_ad_reg[PW-1], p_ad_reg}) - $signed({p_ayd_reg[PW-1], p_ayd_reg});
        end
    end

    assign den_neg = -den_reg;
    assign tn_neg  = -tn_reg;
    assign un_neg  = -un_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2] && valid_reg[1]) begin
            if (den_reg[CW-1]) begin
                mag_reg <= den_neg[DW-1:0];
                tn3_reg <= tn_neg;
                un3_reg <= un_neg;
            end else begin
                mag_reg <= den_reg[DW-1:0];
                tn3_reg <= tn_reg;
                un3_reg <= un_reg;
            end
        end
    end

    // T*2^FRAC / den fits the distance only while tn / 2^COORD_W < den
    assign head     = DW'($unsigned(tn3_reg[CW-1:KW]));
    assign parallel = (mag_reg == '0) || (mag_reg < DW'(tolerance));
    assign t_pos    = !tn3_reg[CW-1] && (tn3_reg != '0);
    assign u_ok     = !un3_reg[CW-1] && (un3_reg <= $signed({2'b00, mag_reg}));

    always_comb begin
        out_next.hit = !parallel && t_pos && u_ok;
        out_next.sat = head >= mag_reg;
        out_next.den = mag_reg;
        out_next.rem = (out_next.hit && !out_next.sat) ? head : '0;
        out_next.dvd = rsi_pkg::DIST_W'(tn3_reg[KW-1:0]) << rsi_pkg::FRAC_W;
        out_next.quo = '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[3] && valid_reg[2]) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hw/rtl/rsi_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div_cell
// One restoring-division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module rsi_div_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  rsi_pkg::rsi_div_t     in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output rsi_pkg::rsi_div_t     out_data,
    input  logic                  out_ready
);

    localparam int DW = rsi_pkg::DEN_W;
    localparam int QW = rsi_pkg::DIST_W;

    logic              valid_reg, valid_next;
    rsi_pkg::rsi_div_t data_reg, data_next;
    logic [DW:0]       trial, diff;
    logic              take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign trial = {in_data.rem, in_data.dvd[QW-1]};
    assign diff  = trial - {1'b0, in_data.den};
    assign take  = trial >= {1'b0, in_data.den};

    always_comb begin
        data_next     = in_data;
        data_next.rem = take ? diff[DW-1:0] : trial[DW-1:0];
        data_next.dvd = {in_data.dvd[QW-2:0], 1'b0};
        data_next.quo = {in_data.quo[QW-2:0], take};
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hw/rtl/ray_segment_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_segment_intersection
// 2D ray/wall segment test, one pair a cycle unless stalled, T in Q16.8.
// ----------------------------------------------------------------------------
// Usage:
//   s_ beats carry one ray/wall pair (eight signed Q8.8 coordinates); each
//   produces exactly one m_ beat with the hit flag and the distance T.
//   cfg_wr_en/cfg_wr_data load the parallel tolerance (Q16.16 units); write
//   it only while no pair is in flight.
// Path: an accepted s_ beat runs through the cross-product and test stages,
//   24 divider cells (one quotient bit each) and the output register, then
//   raises m_tvalid.
// Throughput: one pair per cycle unless the output stalls; the divider is a
//   chain of 24 cells, each retiring one quotient bit, so pairs overlap.
// Reset (aresetn low, synchronous): all pipeline valids clear, the tolerance
//   returns to 1. Pairs in flight are dropped.
// Stall: holding m_tready low freezes the output beat; bubbles in the chain
//   still close up, and an input skid register keeps s_tready registered.
//   Once every stage and the skid are full, s_tready drops.
// ----------------------------------------------------------------------------
module ray_segment_intersection (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rsi_pkg::TOL_W-1:0]     cfg_wr_data,   // parallel_tolerance
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    // wall_start_x, wall_start_y, wall_vec_x, wall_vec_y (16 bits each)
    input  logic [rsi_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit [0], distance [24:1], zero pad [31:25]
    output logic [rsi_pkg::OUT_W-1:0]     m_tdata
);

    localparam int NCELL = rsi_pkg::DIST_W;

    logic [rsi_pkg::TOL_W-1:0] tol_reg;

    // input skid
    logic                skid_valid_reg, skid_valid_next;
    rsi_pkg::rsi_in_t    skid_data_reg;
    logic                front_valid, front_ready;
    rsi_pkg::rsi_in_t    front_data;

    // divider chain
    logic                chain_valid [NCELL+1];
    logic                chain_ready [NCELL+1];
    rsi_pkg::rsi_div_t   chain_data  [NCELL+1];

    // output
    logic                       out_valid_reg, out_valid_next;
    logic [rsi_pkg::DIST_W-1:0] dist_reg;
    logic                       hit_reg;
    logic                       out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= rsi_pkg::TOL_W'(1);
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    assign s_tready    = !skid_valid_reg;
    assign front_valid = skid_valid_reg || s_tvalid;
    assign front_data  = skid_valid_reg ? skid_data_reg : rsi_pkg::rsi_in_t'(s_tdata);

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (front_ready) skid_valid_next = 1'b0;
        end else if (s_tvalid && !front_ready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && s_tvalid && !front_ready) begin
            skid_data_reg <= rsi_pkg::rsi_in_t'(s_tdata);
        end
    end

    rsi_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tolerance (tol_reg),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .in_ready  (front_ready),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_ready (chain_ready[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        rsi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    assign out_ready          = !out_valid_reg || m_tready;
    assign chain_ready[NCELL] = out_ready;
    assign out_valid_next     = out_ready ? chain_valid[NCELL] : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && chain_valid[NCELL]) begin
            hit_reg <= chain_data[NCELL].hit;
            if (!chain_data[NCELL].hit) begin
                dist_reg <= '0;
            end else if (chain_data[NCELL].sat) begin
                dist_reg <= rsi_pkg::DIST_MAX;
            end else begin
                dist_reg <= chain_data[NCELL].quo;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rsi_pkg::OUT_W'({dist_reg, hit_reg});

endmodule

// ----- hw/rtl/rsi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for ray_segment_intersection, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rsi_pkg::OUT_W-1:0] m_tdata
);

    localparam int DW = rsi_pkg::DIST_W;

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high straight after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // a miss carries zero distance, padding stays zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || (m_tdata[DW:1] == '0))
                     && (m_tdata[rsi_pkg::OUT_W-1:DW+1] == '0))
        else $error("miss beat with non-zero distance or padding");

    // input backpressure only starts after a beat was taken into the skid
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready fell with no beat taken");

endmodule

bind ray_segment_intersection rsi_checker u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
